### rtl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, constants and bit-search helpers for the page frame allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

    localparam int MAP_WORDS_DEF = 16384;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = 6;
    localparam int PAGE_W        = 20;
    localparam int CFG_W         = 15;
    // word index width that covers the largest supported map plus one
    localparam int IDX_W         = 17;

    localparam logic [CFG_W-1:0] WIU_RESET = 15'd16384;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_PAGE = 2'd1,
        ST_REJECT  = 2'd2
    } t_status;

    // index of the lowest set bit, zero when none is set
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // index of the highest clear bit, zero when none is clear
    function automatic logic [BIT_W-1:0] highest_zero(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (!v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/pfba_ram.sv
// ----------------------------------------------------------------------------
// pfba_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfba_ram
    import pfba_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = MAP_WORDS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// Allocate steps: summary regs, summary RAM, map RAM, write; the map RAM and
// write steps are skipped when the lowest non-full word lies past the words in
// use. Free: read, then write. Out-of-range free or no free page at all: answered
// from idle. Result waits in a register. Reset: a clearing pass fills every map
// word with ones; no request is taken until it ends, config writes are taken throughout.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator
    import pfba_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_opcode,
    input  logic [PAGE_W-1:0] i_page,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [PAGE_W-1:0] o_allocated_page,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int WW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int L1D  = (MAP_WORDS + WORD_W - 1) / WORD_W;
    localparam int L1AW = (L1D > 1) ? $clog2(L1D) : 1;
    localparam int L2D  = (L1D + WORD_W - 1) / WORD_W;
    localparam int L2AW = (L2D > 1) ? $clog2(L2D) : 1;

    localparam logic [IDX_W-1:0] MAP_I    = IDX_W'(MAP_WORDS);
    localparam logic [IDX_W-1:0] L1D_I    = IDX_W'(L1D);
    localparam logic [WW-1:0]    CLR_LAST = WW'(MAP_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_L2,
        S_FIND_L1,
        S_ALLOC_MAP,
        S_FREE_MAP,
        S_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [WW-1:0]     r_clr, n_clr;
    logic [L2AW-1:0]   r_i2, n_i2;
    logic [BIT_W-1:0]  r_i1, n_i1;
    logic [BIT_W-1:0]  r_i0, n_i0;
    logic [BIT_W-1:0]  r_b, n_b;
    logic [WORD_W-1:0] r_l1w, n_l1w;
    logic [WORD_W-1:0] r_l2w, n_l2w;
    logic [CFG_W-1:0]  r_wiu;

    logic              r_o_valid;
    t_status           r_o_status;
    logic [PAGE_W-1:0] r_o_page;
    t_status           r_p_status;
    logic [PAGE_W-1:0] r_p_page;

    // summary levels: r_l2 bit per L1 word, r_l3 bit per r_l2 word (1 = not full)
    logic [WORD_W-1:0] r_l2 [L2D];
    logic [L2D-1:0]    r_l3;

    logic              accept, out_free;
    logic [IDX_W-1:0]  limit, free_w;
    logic [WORD_W-1:0] l2_rd;
    logic [BIT_W-1:0]  l2_lo, l1_lo, map_hz;
    logic [L2AW+5:0]   a1_find_cat, a1_cur_cat;
    logic [L1AW-1:0]   a1_find, a1_cur;
    logic [IDX_W-1:0]  w_find, w_cur;
    logic [IDX_W+5:0]  alloc_cat;
    logic              clr_in_l1;

    logic              fin;
    t_status           fin_status;
    logic [PAGE_W-1:0] fin_page;

    logic              map_we, map_re;
    logic [WW-1:0]     map_waddr, map_raddr;
    logic [WORD_W-1:0] map_wdata, map_rdata;
    logic              l1_we, l1_re;
    logic [L1AW-1:0]   l1_waddr, l1_raddr;
    logic [WORD_W-1:0] l1_wdata, l1_rdata;
    logic              l2_we, l3_we, l3_val;
    logic [WORD_W-1:0] l2_wdata;

    function automatic logic [L2AW-1:0] lowest_l3(input logic [L2D-1:0] v);
        logic [L2AW-1:0] idx;
        idx = '0;
        for (int i = L2D - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = L2AW'(i);
            end
        end
        return idx;
    endfunction

    pfba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS),
        .AW    (WW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    pfba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (L1D),
        .AW    (L1AW)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (l1_we),
        .i_waddr (l1_waddr),
        .i_wdata (l1_wdata),
        .i_re    (l1_re),
        .i_raddr (l1_raddr),
        .o_rdata (l1_rdata)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_o_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    assign limit  = (IDX_W'(r_wiu) > MAP_I) ? MAP_I : IDX_W'(r_wiu);
    assign free_w = IDX_W'(i_page[PAGE_W-1:BIT_W]);

    assign l2_rd       = r_l2[r_i2];
    assign l2_lo       = lowest_set(l2_rd);
    assign l1_lo       = lowest_set(l1_rdata);
    assign map_hz      = highest_zero(map_rdata);
    assign a1_find_cat = {r_i2, l2_lo};
    assign a1_cur_cat  = {r_i2, r_i1};
    assign a1_find     = a1_find_cat[L1AW-1:0];
    assign a1_cur      = a1_cur_cat[L1AW-1:0];
    assign w_find      = IDX_W'({r_i2, r_i1, l1_lo});
    assign w_cur       = IDX_W'({r_i2, r_i1, r_i0});
    assign alloc_cat   = {w_cur, map_hz};
    assign clr_in_l1   = (IDX_W'(r_clr) < L1D_I);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_i2       = r_i2;
        n_i1       = r_i1;
        n_i0       = r_i0;
        n_b        = r_b;
        n_l1w      = r_l1w;
        n_l2w      = r_l2w;
        fin        = 1'b0;
        fin_status = ST_DONE;
        fin_page   = '0;
        map_re     = 1'b0;
        map_raddr  = w_cur[WW-1:0];
        map_we     = 1'b0;
        map_waddr  = w_cur[WW-1:0];
        map_wdata  = map_rdata;
        l1_re      = 1'b0;
        l1_raddr   = a1_cur;
        l1_we      = 1'b0;
        l1_waddr   = a1_cur;
        l1_wdata   = l1_rdata;
        l2_we      = 1'b0;
        l2_wdata   = l2_rd;
        l3_we      = 1'b0;
        l3_val     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = '1;
                l1_we     = clr_in_l1;
                l1_waddr  = r_clr[L1AW-1:0];
                l1_wdata  = '0;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_ALLOC) begin
                        if (r_l3 == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_NO_PAGE;
                        end else begin
                            n_i2    = lowest_l3(r_l3);
                            n_state = S_FIND_L2;
                        end
                    end else if (free_w < limit) begin
                        n_i2      = free_w[2*BIT_W +: L2AW];
                        n_i1      = free_w[BIT_W +: BIT_W];
                        n_i0      = free_w[BIT_W-1:0];
                        n_b       = i_page[BIT_W-1:0];
                        map_re    = 1'b1;
                        map_raddr = free_w[WW-1:0];
                        l1_re     = 1'b1;
                        l1_raddr  = free_w[BIT_W +: L1AW];
                        n_state   = S_FREE_MAP;
                    end else begin
                        fin        = 1'b1;
                        fin_status = ST_REJECT;
                    end
                end
            end
            S_FIND_L2: begin
                n_l2w    = l2_rd;
                n_i1     = l2_lo;
                l1_re    = 1'b1;
                l1_raddr = a1_find;
                n_state  = S_FIND_L1;
            end
            S_FIND_L1: begin
                n_l1w = l1_rdata;
                n_i0  = l1_lo;
                // the lowest non-full word may lie past the words in use
                if (w_find < limit) begin
                    map_re    = 1'b1;
                    map_raddr = w_find[WW-1:0];
                    n_state   = S_ALLOC_MAP;
                end else begin
                    fin        = 1'b1;
                    fin_status = ST_NO_PAGE;
                    n_state    = S_IDLE;
                end
            end
            S_ALLOC_MAP: begin
                map_we    = 1'b1;
                map_wdata = map_rdata | (WORD_W'(1) << map_hz);
                // word now full: clear its summary bit, and upward if needed
                if (&map_wdata) begin
                    l1_we    = 1'b1;
                    l1_wdata = r_l1w & ~(WORD_W'(1) << r_i0);
                    if (l1_wdata == '0) begin
                        l2_we    = 1'b1;
                        l2_wdata = r_l2w & ~(WORD_W'(1) << r_i1);
                        if (l2_wdata == '0) begin
                            l3_we  = 1'b1;
                            l3_val = 1'b0;
                        end
                    end
                end
                fin        = 1'b1;
                fin_status = ST_DONE;
                fin_page   = alloc_cat[PAGE_W-1:0];
                n_state    = S_IDLE;
            end
            S_FREE_MAP: begin
                if (map_rdata[r_b]) begin
                    map_we     = 1'b1;
                    map_wdata  = map_rdata & ~(WORD_W'(1) << r_b);
                    l1_we      = 1'b1;
                    l1_wdata   = l1_rdata | (WORD_W'(1) << r_i0);
                    l2_we      = 1'b1;
                    l2_wdata   = l2_rd | (WORD_W'(1) << r_i1);
                    l3_we      = 1'b1;
                    l3_val     = 1'b1;
                    fin        = 1'b1;
                    fin_status = ST_DONE;
                end else begin
                    fin        = 1'b1;
                    fin_status = ST_REJECT;
                end
                n_state = S_IDLE;
            end
            S_RESP: begin
                fin        = 1'b1;
                fin_status = r_p_status;
                fin_page   = r_p_page;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // result register still held: park the result
        if (fin && !out_free) begin
            n_state = S_RESP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            r_wiu     <= WIU_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_i2    <= n_i2;
            r_i1    <= n_i1;
            r_i0    <= n_i0;
            r_b     <= n_b;
            r_l1w   <= n_l1w;
            r_l2w   <= n_l2w;
            if (i_cfg_valid) begin
                r_wiu <= i_cfg_data;
            end
            if (fin && out_free) begin
                r_o_valid  <= 1'b1;
                r_o_status <= fin_status;
                r_o_page   <= fin_page;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (fin && !out_free) begin
                r_p_status <= fin_status;
                r_p_page   <= fin_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L2D; k++) begin
                r_l2[k] <= '0;
            end
            r_l3 <= '0;
        end else begin
            if (l2_we) begin
                r_l2[r_i2] <= l2_wdata;
            end
            if (l3_we) begin
                r_l3[r_i2] <= l3_val;
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_allocated_page = r_o_page;

endmodule

### rtl/pfba_checker.sv
// ----------------------------------------------------------------------------
// pfba_checker
// Port-level checks on the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pfba_checker
    import pfba_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_opcode,
    input logic [PAGE_W-1:0] i_page,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_status,
    input logic [PAGE_W-1:0] o_allocated_page,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [CFG_W-1:0]  i_cfg_data
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_allocated_page))
        else $error("result changed while stalled");

    // only a granted allocate carries a page number
    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DONE) |-> o_allocated_page == '0)
        else $error("page number on a failed request");

    // reset starts the clearing pass with no result pending
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("request side open right after reset");

    // config port never pushes back
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: page frame bitmap allocator testbench
// Drives allocate and free requests against a shadow page map kept in the
// bench, checks every reply in order, and walks words_in_use through its
// extremes with random pacing and long output stalls.
// ----------------------------------------------------------------------------
module tb;
    import pfba_pkg::*;

    localparam int MAP_WORDS   = MAP_WORDS_DEF;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] page;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_opcode = OP_ALLOC;
    logic [PAGE_W-1:0] i_page = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic [PAGE_W-1:0] o_allocated_page;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    // shadow of the allocator state
    logic [WORD_W-1:0] shadow_map [MAP_WORDS];
    logic [CFG_W-1:0]  wiu_shadow = WIU_RESET;
    int                first_open = 0;  // every word below this one is full

    t_reply            replies_due [$];
    logic [PAGE_W-1:0] recent_grants [$];
    t_reply            head_reply;

    int n_err = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int hold_left = 0;
    int run_left = 0;
    bit run_stall = 1'b0;
    bit no_idle = 1'b0;

    page_frame_bitmap_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_page           (i_page),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_allocated_page (o_allocated_page),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: long hold when asked, no stall while no_idle, else runs of stall / no stall
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_left  = $urandom_range(1, 8);
                run_stall = ($urandom_range(9) < 4);
            end
            run_left--;
            i_stall <= run_stall;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (replies_due.size() == 0) begin
                $error("reply with none pending: status %0d page %0d",
                       o_status, o_allocated_page);
                n_err++;
            end else begin
                head_reply = replies_due.pop_front();
                if (o_status !== head_reply.status) begin
                    $error("status: expected %0d, got %0d", head_reply.status, o_status);
                    n_err++;
                end
                if (o_allocated_page !== head_reply.page) begin
                    $error("allocated_page: expected %0d, got %0d",
                           head_reply.page, o_allocated_page);
                    n_err++;
                end
            end
        end
    end

    function automatic int active_words();
        return (int'(wiu_shadow) > MAP_WORDS) ? MAP_WORDS : int'(wiu_shadow);
    endfunction

    // apply one request to the shadow map and work out its reply
    function automatic t_reply compute_reply(input logic op, input logic [PAGE_W-1:0] pg);
        t_reply r;
        int     lim;
        int     w;
        int     b;
        lim    = active_words();
        r.page = '0;
        if (op == OP_ALLOC) begin
            r.status = ST_NO_PAGE;
            w = first_open;
            while (w < lim && shadow_map[w] == '1) w++;
            if (w < lim) begin
                b = WORD_W - 1;
                while (shadow_map[w][b]) b--;
                shadow_map[w][b] = 1'b1;
                r.page     = PAGE_W'((w << BIT_W) | b);
                r.status   = ST_DONE;
                first_open = w;
                recent_grants.push_back(r.page);
                if (recent_grants.size() > 64) void'(recent_grants.pop_front());
            end else if (lim > first_open) begin
                first_open = lim;
            end
        end else begin
            r.status = ST_REJECT;
            w = int'(pg >> BIT_W);
            b = int'(pg[BIT_W-1:0]);
            if (w < lim && shadow_map[w][b]) begin
                shadow_map[w][b] = 1'b0;
                r.status = ST_DONE;
                if (w < first_open) first_open = w;
            end
        end
        return r;
    endfunction

    task automatic send_req(input logic op, input logic [PAGE_W-1:0] pg);
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_page   <= pg;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        replies_due.push_back(compute_reply(op, pg));
    endtask

    // sender pacing: bursts of random length, random gaps between unless no_idle is set
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(12);
            if (!no_idle) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic req(input logic op, input logic [PAGE_W-1:0] pg);
        send_req(op, pg);
        pace();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_words_in_use(input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        wiu_shadow = v;
    endtask

    function automatic logic [PAGE_W-1:0] pick_page();
        int span;
        int sel;
        sel  = $urandom_range(9);
        span = active_words() * WORD_W + WORD_W;
        if (span > (1 << PAGE_W)) span = 1 << PAGE_W;
        if (sel < 6) return PAGE_W'($urandom_range(span - 1));
        if (sel < 9 && recent_grants.size() > 0)
            return recent_grants[$urandom_range(recent_grants.size() - 1)];
        return PAGE_W'($urandom());
    endfunction

    task automatic rand_req(input int alloc_pct);
        if ($urandom_range(99) < alloc_pct) req(OP_ALLOC, PAGE_W'($urandom()));
        else req(OP_FREE, pick_page());
    endtask

    // map comes out of reset fully allocated
    task automatic test_reset_map();
        req(OP_ALLOC, '0);
        req(OP_FREE, 20'd0);
        req(OP_FREE, 20'd0);            // already free
        req(OP_FREE, 20'hFFFFF);
        req(OP_ALLOC, 20'hFFFFF);
        req(OP_ALLOC, '0);
        req(OP_ALLOC, 20'h55555);       // map full again
        req(OP_FREE, 20'h55555);
        req(OP_FREE, 20'hAAAAA);
        req(OP_ALLOC, 20'hAAAAA);
        req(OP_ALLOC, '0);
        drain();
    endtask

    task automatic test_register_extremes();
        set_words_in_use('0);           // no word in use
        req(OP_ALLOC, '0);
        req(OP_FREE, 20'd5);
        drain();
        set_words_in_use('1);           // beyond the map, saturates
        req(OP_FREE, 20'hFFFFF);
        req(OP_ALLOC, '0);
        drain();
        set_words_in_use(15'd1);
        req(OP_FREE, 20'd64);           // word not in use
        req(OP_FREE, 20'd63);
        req(OP_FREE, 20'd0);
        req(OP_ALLOC, '0);
        req(OP_ALLOC, '0);
        req(OP_ALLOC, '0);
        drain();
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] wiu_list [9];
        int               n;
        wiu_list = '{15'd1, 15'd2, 15'd3, 15'd16384, 15'd5, 15'd0, 15'd32767, 15'd4, 15'd7};
        foreach (wiu_list[k]) begin
            set_words_in_use(wiu_list[k]);
            n = (wiu_list[k] == 0) ? 40 : 190;
            // free-heavy first half, allocate-heavy second half
            for (int i = 0; i < n; i++) rand_req((i < n / 2) ? 30 : 70);
            drain();
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_output_hold();
        set_words_in_use(15'd2);
        no_idle   = 1'b1;
        hold_left = 400;
        for (int i = 0; i < 80; i++) begin
            if ($urandom_range(1)) send_req(OP_ALLOC, PAGE_W'($urandom()));
            else send_req(OP_FREE, pick_page());
        end
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_back_to_back();
        set_words_in_use(15'd3);
        no_idle = 1'b1;
        for (int i = 0; i < 180; i++) rand_req(50);
        no_idle = 1'b0;
        drain();
        set_words_in_use(WIU_RESET);
    endtask

    initial begin
        for (int w = 0; w < MAP_WORDS; w++) shadow_map[w] = '1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_map();
        test_register_extremes();
        test_random_traffic();
        test_output_hold();
        test_back_to_back();
        drain();
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
